/* rtl/amr_pkg.sv */
`default_nettype none

package amr_pkg;

  localparam int unsigned W_BITS = 9;
  localparam int signed   W_MAX  = 255;
  localparam int unsigned CNT_BITS = 16;
  localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

  typedef enum logic [2:0] {
    OP_WRITE  = 3'd0,
    OP_TRAIN  = 3'd1,
    OP_UPDATE = 3'd2,
    OP_READ   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  localparam logic [0:0] CFG_STEP_LIMIT   = 1'b0;
  localparam logic [0:0] CFG_STABLE_LIMIT = 1'b1;

  // neuron values are kept as 2'b00 (0), 2'b01 (+1), 2'b11 (-1)
  localparam logic [1:0] NV_ZERO = 2'b00;
  localparam logic [1:0] NV_POS  = 2'b01;
  localparam logic [1:0] NV_NEG  = 2'b11;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_WCLR,
    ST_TROW,
    ST_TLOAD,
    ST_TCOL,
    ST_TDRAIN,
    ST_UCOL,
    ST_UOLD,
    ST_UFIN,
    ST_RDN,
    ST_EMIT
  } st_t;

  typedef struct packed {
    logic rd;       // read weight at addr, result handled in the next cycle
    logic clr;      // write zero at addr
    logic acc_clr;  // clear the weighted sum
    logic train;    // issued read is a Hebbian read-modify-write
    logic diag;     // issued read sits on the diagonal
  } wcmd_t;

  typedef struct packed {
    logic [1:0] value;
    logic       changed;
    logic       done;
  } res_t;

  function automatic logic [1:0] dec_val(input logic [1:0] raw);
    logic [1:0] v;
    case (raw)
      2'b00:   v = NV_ZERO;
      2'b01:   v = NV_POS;
      default: v = NV_NEG;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/amr_in_if.sv */
`default_nettype none

interface amr_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        op;
  logic [5:0]        neuron_index;
  logic signed [1:0] neuron_value;

  modport source (output valid, op, neuron_index, neuron_value, input ready);
  modport sink (input valid, op, neuron_index, neuron_value, output ready);
endinterface

`default_nettype wire

/* rtl/amr_out_if.sv */
`default_nettype none

interface amr_out_if;
  logic              valid;
  logic              ready;
  logic signed [1:0] value_out;
  logic              changed;
  logic              done_res;

  modport source (output valid, value_out, changed, done_res, input ready);
  modport sink (input valid, value_out, changed, done_res, output ready);
endinterface

`default_nettype wire

/* rtl/associative_memory_recall.sv */
`default_nettype none

// Hopfield associative memory with Hebbian training. One transaction in gives one
// transaction out. Weights live in a single-port-write NEURONS*NEURONS memory that
// is walked one entry per cycle outside the row setup steps of training, so the
// weight memory port sets the timing: update walks one row of weights, train
// walks the whole matrix once and clear weights writes every entry, while write
// neuron, unused ops and reads or updates with a bad index go straight to the
// result. After reset a clearing pass zeroes weights and neurons before the first
// transaction is taken; configuration writes are taken at any time. A finished
// result waits in an output register while the next transaction is accepted.
module associative_memory_recall #(
  parameter int NEURONS = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  amr_in_if.sink     in_ch,
  amr_out_if.source  out_ch,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  localparam int NW = $clog2(NEURONS);
  localparam int WA = $clog2(NEURONS * NEURONS);
  localparam int SW = $clog2(NEURONS * 255 + 1) + 1;

  logic [15:0] step_limit_r, stable_limit_r;

  logic           idle, res_valid, out_free, in_fire;
  amr_pkg::res_t  res, out_res_r;
  logic           out_valid_r;
  amr_pkg::wcmd_t cmd;
  logic [WA-1:0]  waddr;
  logic [1:0]     ni, nj;
  logic signed [SW-1:0] sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_limit_r   <= 16'd1000;
      stable_limit_r <= 16'd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        amr_pkg::CFG_STEP_LIMIT:   step_limit_r   <= cfg_wdata;
        amr_pkg::CFG_STABLE_LIMIT: stable_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = idle;
  assign in_fire     = in_ch.valid && idle;
  assign out_free    = !out_valid_r || out_ch.ready;

  amr_ctrl #(
    .NEURONS (NEURONS),
    .NW      (NW),
    .WA      (WA),
    .SW      (SW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc_i        (in_fire),
    .op_i         (in_ch.op),
    .idx_i        (in_ch.neuron_index),
    .val_i        (in_ch.neuron_value),
    .step_limit   (step_limit_r),
    .stable_limit (stable_limit_r),
    .emit_ok      (out_free),
    .idle         (idle),
    .res_valid    (res_valid),
    .res          (res),
    .cmd          (cmd),
    .waddr        (waddr),
    .ni           (ni),
    .nj           (nj),
    .sum          (sum)
  );

  amr_weight_store #(
    .NEURONS (NEURONS),
    .WA      (WA),
    .SW      (SW)
  ) u_wstore (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .addr  (waddr),
    .ni    (ni),
    .nj    (nj),
    .sum   (sum)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid && out_free) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.value_out = out_res_r.value;
  assign out_ch.changed   = out_res_r.changed;
  assign out_ch.done_res  = out_res_r.done;

endmodule

`default_nettype wire

/* rtl/amr_weight_store.sv */
`default_nettype none

module amr_weight_store #(
  parameter int NEURONS = 64,
  parameter int WA      = 12,
  parameter int SW      = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire amr_pkg::wcmd_t     cmd,
  input  wire logic [WA-1:0]      addr,
  input  wire logic [1:0]         ni,
  input  wire logic [1:0]         nj,
  output logic signed [SW-1:0]    sum
);

  logic [amr_pkg::W_BITS-1:0] wmem [NEURONS*NEURONS];
  logic [amr_pkg::W_BITS-1:0] wrd_r;

  logic          pv_r, pt_r, pd_r;
  logic [WA-1:0] pa_r;
  logic signed [SW-1:0] sum_r, sum_nxt;

  logic signed [amr_pkg::W_BITS-1:0] w_s;
  logic signed [SW-1:0] w_ext, term;
  logic signed [9:0]    prod, wsum;
  logic signed [amr_pkg::W_BITS-1:0] wnew;
  logic wb_en;

  assign w_s   = $signed(wrd_r);
  assign w_ext = SW'(w_s);
  assign wb_en = pv_r && pt_r && !pd_r;

  always_comb begin
    term = '0;
    if (nj[0]) begin
      term = nj[1] ? -w_ext : w_ext;
    end
    sum_nxt = sum_r;
    if (cmd.acc_clr) begin
      sum_nxt = '0;
    end else if (pv_r && !pt_r) begin
      sum_nxt = sum_r + term;
    end
  end

  always_comb begin
    prod = 10'sd0;
    if (ni[0] && nj[0]) begin
      prod = (ni[1] ^ nj[1]) ? -10'sd1 : 10'sd1;
    end
    wsum = 10'(w_s) + prod;
    if (wsum > 10'(amr_pkg::W_MAX)) begin
      wnew = 9'(amr_pkg::W_MAX);
    end else if (wsum < -10'(amr_pkg::W_MAX)) begin
      wnew = -9'(amr_pkg::W_MAX);
    end else begin
      wnew = wsum[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      wmem[addr] <= '0;
    end else if (wb_en) begin
      wmem[pa_r] <= wnew;
    end
    if (cmd.rd) begin
      wrd_r <= wmem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= cmd.rd;
    end
    pt_r  <= cmd.train;
    pd_r  <= cmd.diag;
    pa_r  <= addr;
    sum_r <= sum_nxt;
  end

  assign sum = sum_r;

`ifndef SYNTH
  a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clr && wb_en))
    else $error("weight clear collides with training write-back");
`endif

endmodule

`default_nettype wire

/* rtl/amr_ctrl.sv */
`default_nettype none

module amr_ctrl #(
  parameter int NEURONS = 64,
  parameter int NW      = 6,
  parameter int WA      = 12,
  parameter int SW      = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 acc_i,
  input  wire logic [2:0]           op_i,
  input  wire logic [5:0]           idx_i,
  input  wire logic [1:0]           val_i,
  input  wire logic [15:0]          step_limit,
  input  wire logic [15:0]          stable_limit,
  input  wire logic                 emit_ok,
  output logic                      idle,
  output logic                      res_valid,
  output amr_pkg::res_t             res,
  output amr_pkg::wcmd_t            cmd,
  output logic [WA-1:0]             waddr,
  output logic [1:0]                ni,
  output logic [1:0]                nj,
  input  wire logic signed [SW-1:0] sum
);

  amr_pkg::st_t st_r, st_nxt;

  logic [NW-1:0] i_r, i_nxt, j_r, j_nxt, idx_r, idx_nxt;
  logic [WA-1:0] waddr_r, waddr_nxt;
  logic [1:0]    ni_r, ni_nxt;
  logic [15:0]   step_r, step_nxt, stable_r, stable_nxt;
  amr_pkg::res_t res_r, res_nxt;

  logic [1:0]    nmem [NEURONS];
  logic [1:0]    nrd_r;
  logic          nwe;
  logic [NW-1:0] nwa, nra;
  logic [1:0]    nwd;

  logic [NW-1:0] in_idx;
  logic          idx_ok, last_j, last_i;
  logic [1:0]    nv;
  logic          chg;

  assign in_idx = NW'(idx_i);
  assign idx_ok = 32'(idx_i) < NEURONS;
  assign last_j = j_r == NW'(NEURONS - 1);
  assign last_i = i_r == NW'(NEURONS - 1);

  assign nv  = (sum == '0) ? amr_pkg::NV_ZERO :
               (sum[SW-1] ? amr_pkg::NV_NEG : amr_pkg::NV_POS);
  assign chg = nv != nrd_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      amr_pkg::ST_INIT: begin
        if (last_i && last_j) st_nxt = amr_pkg::ST_IDLE;
      end
      amr_pkg::ST_IDLE: begin
        if (acc_i) begin
          case (op_i)
            amr_pkg::OP_TRAIN:  st_nxt = amr_pkg::ST_TROW;
            amr_pkg::OP_UPDATE: st_nxt = idx_ok ? amr_pkg::ST_UCOL : amr_pkg::ST_EMIT;
            amr_pkg::OP_READ:   st_nxt = idx_ok ? amr_pkg::ST_RDN : amr_pkg::ST_EMIT;
            amr_pkg::OP_CLEAR:  st_nxt = amr_pkg::ST_WCLR;
            default:            st_nxt = amr_pkg::ST_EMIT;
          endcase
        end
      end
      amr_pkg::ST_WCLR: begin
        if (last_i && last_j) st_nxt = amr_pkg::ST_EMIT;
      end
      amr_pkg::ST_TROW:  st_nxt = amr_pkg::ST_TLOAD;
      amr_pkg::ST_TLOAD: st_nxt = amr_pkg::ST_TCOL;
      amr_pkg::ST_TCOL: begin
        if (last_j) st_nxt = last_i ? amr_pkg::ST_TDRAIN : amr_pkg::ST_TROW;
      end
      amr_pkg::ST_TDRAIN: st_nxt = amr_pkg::ST_EMIT;
      amr_pkg::ST_UCOL: begin
        if (last_j) st_nxt = amr_pkg::ST_UOLD;
      end
      amr_pkg::ST_UOLD: st_nxt = amr_pkg::ST_UFIN;
      amr_pkg::ST_UFIN: st_nxt = amr_pkg::ST_EMIT;
      amr_pkg::ST_RDN:  st_nxt = amr_pkg::ST_EMIT;
      amr_pkg::ST_EMIT: begin
        if (emit_ok) st_nxt = amr_pkg::ST_IDLE;
      end
      default: st_nxt = amr_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    i_nxt      = i_r;
    j_nxt      = j_r;
    waddr_nxt  = waddr_r;
    idx_nxt    = idx_r;
    ni_nxt     = ni_r;
    step_nxt   = step_r;
    stable_nxt = stable_r;
    res_nxt    = res_r;
    nwe        = 1'b0;
    nwa        = j_r;
    nwd        = amr_pkg::NV_ZERO;
    nra        = j_r;
    cmd        = '0;

    unique case (st_r)
      amr_pkg::ST_INIT, amr_pkg::ST_WCLR, amr_pkg::ST_TLOAD,
      amr_pkg::ST_TCOL, amr_pkg::ST_UCOL: begin
        // one matrix entry per cycle, row-major
        j_nxt     = last_j ? '0 : j_r + 1'b1;
        i_nxt     = last_j ? i_r + 1'b1 : i_r;
        waddr_nxt = waddr_r + 1'b1;
      end
      default: ;
    endcase

    unique case (st_r)
      amr_pkg::ST_INIT: begin
        cmd.clr = 1'b1;
        nwe     = 1'b1;
      end
      amr_pkg::ST_IDLE: begin
        nra = in_idx;
        if (acc_i) begin
          idx_nxt   = in_idx;
          i_nxt     = '0;
          j_nxt     = '0;
          waddr_nxt = '0;
          res_nxt   = '0;
          case (op_i)
            amr_pkg::OP_WRITE: begin
              step_nxt   = '0;
              stable_nxt = '0;
              if (idx_ok) begin
                nwe           = 1'b1;
                nwa           = in_idx;
                nwd           = amr_pkg::dec_val(val_i);
                res_nxt.value = amr_pkg::dec_val(val_i);
              end
            end
            amr_pkg::OP_UPDATE: begin
              cmd.acc_clr = 1'b1;
              waddr_nxt   = WA'(in_idx * NEURONS);
            end
            default: ;
          endcase
        end
      end
      amr_pkg::ST_WCLR: cmd.clr = 1'b1;
      amr_pkg::ST_TROW: nra = i_r;
      amr_pkg::ST_TLOAD, amr_pkg::ST_TCOL: begin
        if (st_r == amr_pkg::ST_TLOAD) ni_nxt = nrd_r;
        cmd.rd    = 1'b1;
        cmd.train = 1'b1;
        cmd.diag  = i_r == j_r;
      end
      amr_pkg::ST_UCOL: cmd.rd = 1'b1;
      amr_pkg::ST_UOLD: nra = idx_r;
      amr_pkg::ST_UFIN: begin
        nwe        = 1'b1;
        nwa        = idx_r;
        nwd        = nv;
        step_nxt   = (step_r == amr_pkg::CNT_MAX) ? step_r : step_r + 1'b1;
        stable_nxt = chg ? '0 :
                     ((stable_r == amr_pkg::CNT_MAX) ? stable_r : stable_r + 1'b1);
        res_nxt.value   = nv;
        res_nxt.changed = chg;
        res_nxt.done    = (step_nxt >= step_limit) || (stable_nxt >= stable_limit);
      end
      amr_pkg::ST_RDN: begin
        res_nxt.value = nrd_r;
        res_nxt.done  = (step_r >= step_limit) || (stable_r >= stable_limit);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (nwe) begin
      nmem[nwa] <= nwd;
    end
    nrd_r <= nmem[nra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= amr_pkg::ST_INIT;
      i_r      <= '0;
      j_r      <= '0;
      waddr_r  <= '0;
      step_r   <= '0;
      stable_r <= '0;
    end else begin
      st_r     <= st_nxt;
      i_r      <= i_nxt;
      j_r      <= j_nxt;
      waddr_r  <= waddr_nxt;
      step_r   <= step_nxt;
      stable_r <= stable_nxt;
    end
    idx_r <= idx_nxt;
    ni_r  <= ni_nxt;
    res_r <= res_nxt;
  end

  assign idle      = st_r == amr_pkg::ST_IDLE;
  assign res_valid = st_r == amr_pkg::ST_EMIT;
  assign res       = res_r;
  assign waddr     = waddr_r;
  assign ni        = ni_r;
  assign nj        = nrd_r;

`ifndef SYNTH
  a_write_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == amr_pkg::ST_IDLE && acc_i && op_i == amr_pkg::OP_WRITE)
    |=> (step_r == '0 && stable_r == '0))
    else $error("write transaction did not clear step counters");

  a_stable_le_step: assert property (@(posedge clk) disable iff (!rst_n)
    stable_r <= step_r)
    else $error("stable count exceeds step count");

  a_update_emits: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == amr_pkg::ST_UFIN |=> st_r == amr_pkg::ST_EMIT)
    else $error("update finish not followed by result");
`endif

endmodule

`default_nettype wire
